// ----- src/bfsp_pkg.sv -----
// Shared types and constants for the shortest-path block.
package bfsp_pkg;

   localparam int VERTEX_W     = 5;
   localparam int CNT_W        = 6;
   localparam int RESULT_LIMIT = 32;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_RUN   = 1'b1;

   typedef struct packed {
      logic accept;
      logic clr_step;
      logic rd_u;
      logic lat_u;
      logic relax;
      logic adv_col;
      logic adv_row;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_run;
      logic src_ok;
      logic u_reach;
      logic v_last;
      logic u_last;
      logic pass_last;
      logic rsp_taken;
   } status_type;

endpackage

// ----- src/bfsp_ram.sv -----
// Generic single-write, single-read memory with registered read data.
module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bfsp_ctrl.sv -----
// Sequencer for edge writes, relaxation sweeps and result transfers.
module bfsp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output bfsp_pkg::cmd_type     cmd,
   input  bfsp_pkg::status_type  st
);

   import bfsp_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_ROW     = 9'b000000100,
      S_ROWLAT  = 9'b000001000,
      S_PAIR_RD = 9'b000010000,
      S_PAIR_EV = 9'b000100000,
      S_OUT_RD  = 9'b001000000,
      S_OUT_LD  = 9'b010000000,
      S_OUT_WT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (st.is_run) begin
                  state_in = st.src_ok ? S_ROW : S_OUT_RD;
               end
            end
         end
         S_ROW: begin
            cmd.rd_u = 1'b1;
            if (st.u_reach) begin
               state_in = S_ROWLAT;
            end else begin
               cmd.adv_row = 1'b1;
               state_in    = (st.u_last && st.pass_last) ? S_OUT_RD : S_ROW;
            end
         end
         S_ROWLAT: begin
            cmd.lat_u = 1'b1;
            state_in  = S_PAIR_RD;
         end
         S_PAIR_RD: begin
            state_in = S_PAIR_EV;
         end
         S_PAIR_EV: begin
            cmd.relax = 1'b1;
            if (st.v_last) begin
               cmd.adv_row = 1'b1;
               state_in    = (st.u_last && st.pass_last) ? S_OUT_RD : S_ROW;
            end else begin
               cmd.adv_col = 1'b1;
               state_in    = S_PAIR_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT_WT;
         end
         S_OUT_WT: begin
            if (st.rsp_taken) begin
               if (st.v_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.adv_col = 1'b1;
                  state_in    = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_run_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept && st.is_run |=> state_ff != S_IDLE)
      else $error("run start did not leave idle");

   a_last_transfer_ends_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT_WT && st.rsp_taken && st.v_last |=> state_ff == S_IDLE)
      else $error("final result transfer did not end the run");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

endmodule

// ----- src/bfsp_dp.sv -----
// Datapath: edge, distance and predecessor stores, counters, relaxation and result register.
module bfsp_dp #(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16,
   parameter int DIST_BITS    = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bfsp_pkg::cmd_type                     cmd,
   output bfsp_pkg::status_type                  st,
   input  logic                                  csr_valid,
   input  logic [bfsp_pkg::CNT_W-1:0]            csr_vertex_count,
   input  logic                                  req_mode,
   input  logic [bfsp_pkg::VERTEX_W-1:0]         req_from_vertex,
   input  logic [bfsp_pkg::VERTEX_W-1:0]         req_to_vertex,
   input  logic signed [WEIGHT_BITS-1:0]         req_edge_weight,
   input  logic                                  req_edge_present,
   input  logic [bfsp_pkg::VERTEX_W-1:0]         req_source_vertex,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bfsp_pkg::VERTEX_W-1:0]         rsp_vertex,
   output logic signed [DIST_BITS-1:0]           rsp_path_distance,
   output logic                                  rsp_reachable,
   output logic [bfsp_pkg::VERTEX_W-1:0]         rsp_predecessor,
   output logic                                  rsp_has_predecessor,
   output logic                                  rsp_last
);

   import bfsp_pkg::*;

   localparam int VIDX_W  = $clog2(MAX_VERTICES);
   localparam int EDGES   = MAX_VERTICES * MAX_VERTICES;
   localparam int EDGE_AW = $clog2(EDGES);
   localparam int LIMIT   = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;
   localparam int SUM_W   = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
   localparam logic signed [SUM_W-1:0] DMAX = SUM_W'({1'b0, {(DIST_BITS-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] DMIN = ~DMAX;

   logic [CNT_W-1:0]          count_ff, count_in, count_m1;
   logic [EDGE_AW-1:0]        clr_addr_ff, clr_addr_in;
   logic [VIDX_W-1:0]         u_ff, u_in, v_ff, v_in, pass_ff, pass_in;
   logic [MAX_VERTICES-1:0]   reach_ff, reach_in, pvalid_ff, pvalid_in;
   logic signed [DIST_BITS-1:0] dist_u_ff, dist_u_in;

   logic                      run_start, edge_wr, upd;
   logic [VIDX_W-1:0]         src_idx;
   logic [EDGE_AW-1:0]        edge_wr_addr, edge_rd_addr, edge_addr;
   logic [WEIGHT_BITS:0]      edge_wr_data, edge_data, edge_rd;
   logic                      edge_we;
   logic [VIDX_W-1:0]         dist_rd_addr, dist_wr_addr;
   logic [DIST_BITS-1:0]      dist_wr_data, dist_rd;
   logic                      dist_we;
   logic [VIDX_W-1:0]         pred_rd;
   logic signed [WEIGHT_BITS-1:0] weight;
   logic signed [DIST_BITS-1:0]   dist_v;
   logic signed [SUM_W-1:0]   sum;
   logic signed [DIST_BITS-1:0] sat_sum;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]       rsp_vertex_ff, rsp_pred_ff;
   logic signed [DIST_BITS-1:0] rsp_dist_ff;
   logic                      rsp_reach_ff, rsp_haspred_ff, rsp_last_ff;

   // Vertex count register, clamped on write
   always_comb begin
      count_in = count_ff;
      if (csr_valid) begin
         if (csr_vertex_count == '0) begin
            count_in = CNT_W'(1);
         end else if (int'(csr_vertex_count) > LIMIT) begin
            count_in = CNT_W'(LIMIT);
         end else begin
            count_in = csr_vertex_count;
         end
      end
   end

   assign count_m1  = count_ff - CNT_W'(1);
   assign src_idx   = VIDX_W'(req_source_vertex);
   assign run_start = cmd.accept && (req_mode == MODE_RUN);
   assign edge_wr   = cmd.accept && (req_mode == MODE_WRITE)
                      && (int'(req_from_vertex) < MAX_VERTICES)
                      && (int'(req_to_vertex) < MAX_VERTICES);

   assign st.clr_last  = (clr_addr_ff == EDGE_AW'(EDGES - 1));
   assign st.is_run    = (req_mode == MODE_RUN);
   assign st.src_ok    = ({1'b0, req_source_vertex} < count_ff);
   assign st.u_reach   = reach_ff[u_ff];
   assign st.v_last    = (CNT_W'(v_ff) == count_m1);
   assign st.u_last    = (CNT_W'(u_ff) == count_m1);
   assign st.pass_last = (CNT_W'(pass_ff) == count_m1);
   assign st.rsp_taken = rsp_valid_ff && !rsp_stall;

   // Edge store
   assign edge_wr_addr = EDGE_AW'(req_from_vertex) * EDGE_AW'(MAX_VERTICES)
                         + EDGE_AW'(req_to_vertex);
   assign edge_rd_addr = EDGE_AW'(u_ff) * EDGE_AW'(MAX_VERTICES) + EDGE_AW'(v_ff);
   assign edge_we      = cmd.clr_step || edge_wr;
   assign edge_addr    = cmd.clr_step ? clr_addr_ff : edge_wr_addr;
   assign edge_wr_data = {req_edge_present, req_edge_weight};
   assign edge_data    = cmd.clr_step ? '0 : edge_wr_data;

   bfsp_ram #(.WIDTH(WEIGHT_BITS + 1), .DEPTH(EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_addr),
      .wr_data (edge_data),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd)
   );

   // Relaxation
   assign weight  = edge_rd[WEIGHT_BITS-1:0];
   assign dist_v  = dist_rd;
   assign sum     = SUM_W'(dist_u_ff) + SUM_W'(weight);

   always_comb begin
      if (sum > DMAX) begin
         sat_sum = DMAX[DIST_BITS-1:0];
      end else if (sum < DMIN) begin
         sat_sum = DMIN[DIST_BITS-1:0];
      end else begin
         sat_sum = sum[DIST_BITS-1:0];
      end
   end

   assign upd = cmd.relax && edge_rd[WEIGHT_BITS] && (!reach_ff[v_ff] || sat_sum < dist_v);

   // Distance and predecessor stores
   assign dist_rd_addr = cmd.rd_u ? u_ff : v_ff;
   assign dist_we      = upd || (run_start && st.src_ok);
   assign dist_wr_addr = upd ? v_ff : src_idx;
   assign dist_wr_data = upd ? sat_sum : '0;

   bfsp_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd)
   );

   bfsp_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_pred_ram (
      .clock   (clock),
      .wr_en   (upd),
      .wr_addr (v_ff),
      .wr_data (u_ff),
      .rd_addr (v_ff),
      .rd_data (pred_rd)
   );

   // Counters, flags and the current row distance
   always_comb begin
      clr_addr_in = cmd.clr_step ? clr_addr_ff + EDGE_AW'(1) : clr_addr_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      pass_in     = pass_ff;
      reach_in    = reach_ff;
      pvalid_in   = pvalid_ff;
      dist_u_in   = dist_u_ff;
      if (run_start) begin
         u_in      = '0;
         v_in      = '0;
         pass_in   = '0;
         reach_in  = '0;
         pvalid_in = '0;
         if (st.src_ok) begin
            reach_in[src_idx] = 1'b1;
         end
      end else if (cmd.adv_col) begin
         v_in = v_ff + VIDX_W'(1);
      end else if (cmd.adv_row) begin
         v_in = '0;
         if (st.u_last) begin
            u_in    = '0;
            pass_in = pass_ff + VIDX_W'(1);
         end else begin
            u_in = u_ff + VIDX_W'(1);
         end
      end
      if (upd) begin
         reach_in[v_ff]  = 1'b1;
         pvalid_in[v_ff] = 1'b1;
      end
      if (cmd.lat_u) begin
         dist_u_in = dist_rd;
      end else if (upd && v_ff == u_ff) begin
         dist_u_in = sat_sum;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (st.rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_W'(LIMIT);
         clr_addr_ff  <= '0;
         u_ff         <= '0;
         v_ff         <= '0;
         pass_ff      <= '0;
         reach_ff     <= '0;
         pvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         u_ff         <= u_in;
         v_ff         <= v_in;
         pass_ff      <= pass_in;
         reach_ff     <= reach_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_u_ff <= dist_u_in;
      if (cmd.out_load) begin
         rsp_vertex_ff  <= VERTEX_W'(v_ff);
         rsp_dist_ff    <= reach_ff[v_ff] ? dist_rd : '0;
         rsp_reach_ff   <= reach_ff[v_ff];
         rsp_pred_ff    <= pvalid_ff[v_ff] ? VERTEX_W'(pred_rd) : '0;
         rsp_haspred_ff <= pvalid_ff[v_ff];
         rsp_last_ff    <= st.v_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vertex          = rsp_vertex_ff;
   assign rsp_path_distance   = rsp_dist_ff;
   assign rsp_reachable       = rsp_reach_ff;
   assign rsp_predecessor     = rsp_pred_ff;
   assign rsp_has_predecessor = rsp_haspred_ff;
   assign rsp_last            = rsp_last_ff;

   a_upd_marks_reached: assert property (@(posedge clock) disable iff (reset)
      upd && !run_start |=> reach_ff[$past(v_ff)] && pvalid_ff[$past(v_ff)])
      else $error("relaxed vertex not marked reached");

   a_self_loop_tracks_row: assert property (@(posedge clock) disable iff (reset)
      upd && v_ff == u_ff |=> dist_u_ff == $past(sat_sum))
      else $error("row distance missed a self-loop update");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result valid without a load");

endmodule

// ----- src/bellman_ford_shortest_paths.sv -----
// Bellman-Ford single-source shortest paths over an internal adjacency matrix.
// After reset the block sweeps the edge memory to empty, one entry a cycle,
// and holds req_stall high meanwhile; csr writes are taken throughout. An edge
// write (mode 0) is stored when accepted. A run (mode 1) with a valid source
// makes n passes; in each pass a row whose vertex is not yet reached is skipped,
// and a reached row latches its distance, then reads and relaxes each (u,v) pair
// in turn through the registered edge memory read. A run whose source is n or
// more makes no passes. The n results then leave one at a time, each held
// until it is taken with rsp_stall low. One item is in work at a time.
module bellman_ford_shortest_paths #(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16,
   parameter int DIST_BITS    = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [5:0]                    csr_vertex_count,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [4:0]                    req_from_vertex,
   input  logic [4:0]                    req_to_vertex,
   input  logic signed [WEIGHT_BITS-1:0] req_edge_weight,
   input  logic                          req_edge_present,
   input  logic [4:0]                    req_source_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [4:0]                    rsp_vertex,
   output logic signed [DIST_BITS-1:0]   rsp_path_distance,
   output logic                          rsp_reachable,
   output logic [4:0]                    rsp_predecessor,
   output logic                          rsp_has_predecessor,
   output logic                          rsp_last
);

   import bfsp_pkg::*;

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   bfsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .st        (st)
   );

   bfsp_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS),
      .DIST_BITS    (DIST_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .csr_valid           (csr_valid),
      .csr_vertex_count    (csr_vertex_count),
      .req_mode            (req_mode),
      .req_from_vertex     (req_from_vertex),
      .req_to_vertex       (req_to_vertex),
      .req_edge_weight     (req_edge_weight),
      .req_edge_present    (req_edge_present),
      .req_source_vertex   (req_source_vertex),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_vertex          (rsp_vertex),
      .rsp_path_distance   (rsp_path_distance),
      .rsp_reachable       (rsp_reachable),
      .rsp_predecessor     (rsp_predecessor),
      .rsp_has_predecessor (rsp_has_predecessor),
      .rsp_last            (rsp_last)
   );

endmodule
